[rtl/core/telemetry_frame_resync_deframer_unit_defines.svh]
// Assertion macros for the telemetry frame resync deframer.
// Included by the top level; depends on nothing else.
`ifndef TELEMETRY_FRAME_RESYNC_DEFRAMER_UNIT_DEFINES_SVH
`define TELEMETRY_FRAME_RESYNC_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TFRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tfrd_pkg.sv]
// Shared types and constants of the telemetry frame resync deframer.
// No dependencies; used by the interfaces and every module.
package tfrd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] nibble_t;
  typedef logic [1:0] cfg_idx_t;

  localparam int MARKER_MAX   = 8;
  localparam int MARKER_IDX_W = 3;

  // Transmit-complete marker: 0x02 followed by zeros.
  localparam byte_t MARKER_PATTERN [MARKER_MAX] = '{
    8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam cfg_idx_t CFG_IDX_TYPE_CODE = 2'd0;
  localparam cfg_idx_t CFG_IDX_TOP_ID    = 2'd1;

  localparam nibble_t TYPE_CODE_RST = 4'd1;
  localparam nibble_t TOP_ID_RST    = 4'd11;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MCHK,
    ST_HDR,
    ST_EMIT,
    ST_FLUSH
  } tfrd_state_t;

  typedef struct packed {
    nibble_t frame_type_code;
    nibble_t top_source_id;
  } tfrd_cfg_t;

  typedef struct packed {
    logic  out_kind;
    byte_t out_byte;
    logic  last_of_run;
  } tfrd_result_t;

  typedef struct packed {
    logic idle;
    logic pend_mark;
  } tfrd_status_t;

endpackage

[rtl/core/tfrd_in_if.sv]
// Input byte channel of the deframer.
// Depends on tfrd_pkg.
interface tfrd_in_if;
  logic            valid;
  logic            ready;
  tfrd_pkg::byte_t rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink   (input valid, rx_byte, output ready);
endinterface

[rtl/core/tfrd_out_if.sv]
// Result channel of the deframer: frame bytes and marker events.
// Depends on tfrd_pkg.
interface tfrd_out_if;
  logic            valid;
  logic            ready;
  logic            out_kind;
  tfrd_pkg::byte_t out_byte;
  logic            last_of_run;

  modport source (output valid, out_kind, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_kind, out_byte, last_of_run, output ready);
endinterface

[rtl/core/tfrd_cfg_if.sv]
// Configuration write channel of the deframer.
// Depends on tfrd_pkg.
interface tfrd_cfg_if;
  logic               valid;
  logic               ready;
  tfrd_pkg::cfg_idx_t idx;
  tfrd_pkg::nibble_t  data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

[rtl/core/tfrd_window_mem.sv]
// Window byte store: one write port, one read port, registered read data.
// Depends on tfrd_pkg.
module tfrd_window_mem #(
  parameter int unsigned DEPTH = 22
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  tfrd_pkg::byte_t            wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output tfrd_pkg::byte_t            rd_data
);

  tfrd_pkg::byte_t mem_q [DEPTH];
  tfrd_pkg::byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/tfrd_seq.sv]
// Deframer sequencer: circular window pointers, marker and header checks.
// Depends on tfrd_pkg; drives tfrd_window_mem ports and the result stage.
module tfrd_seq #(
  parameter int unsigned FRAME_BYTES  = 22,
  parameter int unsigned MARKER_BYTES = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tfrd_pkg::tfrd_cfg_t            cfg,
  input  logic                           in_valid,
  input  tfrd_pkg::byte_t                in_byte,
  output logic                           in_ready,
  output logic                           wr_en,
  output logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  output tfrd_pkg::byte_t                wr_data,
  output logic                           rd_en,
  output logic [$clog2(FRAME_BYTES)-1:0] rd_addr,
  input  tfrd_pkg::byte_t                rd_data,
  output logic                           res_valid,
  output tfrd_pkg::tfrd_result_t         res,
  input  logic                           res_ready,
  output tfrd_pkg::tfrd_status_t         status
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam int SW = FW + 1;
  localparam int MIW = tfrd_pkg::MARKER_IDX_W;
  localparam bit MARK_EN = (MARKER_BYTES <= FRAME_BYTES) &&
                           (MARKER_BYTES <= tfrd_pkg::MARKER_MAX);

  tfrd_pkg::tfrd_state_t state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;

  logic in_fire, hdr_ok, mk_hit, mk_last, mk_ready, win_full, emit_last;

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p,
                                            input logic [FW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(p) + SW'(k);
    if (sum >= SW'(FRAME_BYTES)) begin
      sum = sum - SW'(FRAME_BYTES);
    end
    return sum[PW-1:0];
  endfunction

  assign in_fire   = in_valid && in_ready;
  assign hdr_ok    = (rd_data[3:0] == cfg.frame_type_code) &&
                     (rd_data[7:4] <= cfg.top_source_id);
  assign mk_hit    = MARK_EN && (rd_data == tfrd_pkg::MARKER_PATTERN[idx_r[MIW-1:0]]);
  assign mk_last   = ({1'b0, idx_r} == SW'(MARKER_BYTES - 1));
  assign mk_ready  = MARK_EN && ({1'b0, fill_r} >= SW'(MARKER_BYTES));
  assign win_full  = (fill_r == FW'(FRAME_BYTES));
  assign emit_last = (idx_r == FW'(FRAME_BYTES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfrd_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = tfrd_pkg::ST_CHECK;
      end
      tfrd_pkg::ST_CHECK: begin
        if (mk_ready)      state_nxt = tfrd_pkg::ST_MCHK;
        else if (win_full) state_nxt = tfrd_pkg::ST_HDR;
        else if (pend_r)   state_nxt = tfrd_pkg::ST_FLUSH;
        else               state_nxt = tfrd_pkg::ST_IDLE;
      end
      tfrd_pkg::ST_MCHK: begin
        if (!mk_hit) begin
          if (win_full)    state_nxt = tfrd_pkg::ST_HDR;
          else if (pend_r) state_nxt = tfrd_pkg::ST_FLUSH;
          else             state_nxt = tfrd_pkg::ST_IDLE;
        end else if (mk_last && (!pend_r || res_ready)) begin
          state_nxt = tfrd_pkg::ST_CHECK;
        end
      end
      tfrd_pkg::ST_HDR: begin
        state_nxt = hdr_ok ? tfrd_pkg::ST_EMIT : tfrd_pkg::ST_CHECK;
      end
      tfrd_pkg::ST_EMIT: begin
        if (res_ready && emit_last) state_nxt = tfrd_pkg::ST_IDLE;
      end
      tfrd_pkg::ST_FLUSH: begin
        if (res_ready) state_nxt = tfrd_pkg::ST_IDLE;
      end
      default: state_nxt = tfrd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ptr_add(head_r, fill_r);
    wr_data   = in_byte;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    res_valid = 1'b0;
    res       = '{out_kind: tfrd_pkg::KIND_FRAME, out_byte: rd_data, last_of_run: 1'b0};
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      tfrd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        wr_en    = in_fire;
        if (in_fire) fill_nxt = fill_r + FW'(1);
      end
      tfrd_pkg::ST_CHECK: begin
        if (mk_ready || win_full) begin
          rd_en   = 1'b1;
          idx_nxt = '0;
        end
      end
      tfrd_pkg::ST_MCHK: begin
        if (!mk_hit) begin
          rd_en = win_full;
        end else if (mk_last) begin
          // A held marker goes out as not-last once another marker is found.
          if (!pend_r || res_ready) begin
            res_valid = pend_r;
            res       = '{out_kind: tfrd_pkg::KIND_MARKER, out_byte: '0,
                          last_of_run: 1'b0};
            head_nxt  = ptr_add(head_r, FW'(MARKER_BYTES));
            fill_nxt  = fill_r - FW'(MARKER_BYTES);
            pend_nxt  = 1'b1;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_add(head_r, idx_r + FW'(1));
          idx_nxt = idx_r + FW'(1);
        end
      end
      tfrd_pkg::ST_HDR: begin
        if (hdr_ok) begin
          idx_nxt = '0;
        end else begin
          // Slip one byte.
          head_nxt = ptr_add(head_r, FW'(1));
          fill_nxt = fill_r - FW'(1);
        end
      end
      tfrd_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        res       = '{out_kind: tfrd_pkg::KIND_FRAME, out_byte: rd_data,
                      last_of_run: emit_last};
        if (res_ready) begin
          if (emit_last) begin
            fill_nxt = '0;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_add(head_r, idx_r + FW'(1));
            idx_nxt = idx_r + FW'(1);
          end
        end
      end
      tfrd_pkg::ST_FLUSH: begin
        res_valid = 1'b1;
        res       = '{out_kind: tfrd_pkg::KIND_MARKER, out_byte: '0, last_of_run: 1'b1};
        if (res_ready) pend_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfrd_pkg::ST_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign status = '{idle: (state_r == tfrd_pkg::ST_IDLE), pend_mark: pend_r};

endmodule

[rtl/core/tfrd_out_reg.sv]
// Result output register between the sequencer and the result channel.
// Depends on tfrd_pkg and tfrd_out_if.
module tfrd_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  tfrd_pkg::tfrd_result_t res,
  output logic                   res_ready,
  tfrd_out_if.source             out_ch
);

  logic                   valid_r;
  tfrd_pkg::tfrd_result_t data_r;

  assign res_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_kind    = data_r.out_kind;
  assign out_ch.out_byte    = data_r.out_byte;
  assign out_ch.last_of_run = data_r.last_of_run;

endmodule

[rtl/core/telemetry_frame_resync_deframer_unit.sv]
// Top level of the telemetry frame resync deframer: config registers and wiring.
// Depends on tfrd_pkg, the tfrd_*_if interfaces, tfrd_seq, tfrd_window_mem, tfrd_out_reg.
//
//   Channel  Dir  Payload                               Transaction when
//   in_ch    in   rx_byte[7:0]                          valid && ready
//   out_ch   out  out_kind, out_byte[7:0], last_of_run  valid && ready
//   cfg_ch   in   idx[1:0], data[3:0]                   valid && ready (ready always 1)
//
// One byte is taken at a time; the next is taken once its run has finished.
// Per byte, through one memory read port: append and first check, then as needed
// marker checks, slips, header checks, the emission of a frame and the release of a
// held marker event.
// A held result stalls the sequencer only when it must emit.
// Reset clears pointers and fill and loads the config reset values; the window memory is not cleared.
`include "telemetry_frame_resync_deframer_unit_defines.svh"

module telemetry_frame_resync_deframer_unit #(
  parameter int unsigned FRAME_BYTES  = 22,
  parameter int unsigned MARKER_BYTES = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  tfrd_in_if.sink    in_ch,
  tfrd_out_if.source out_ch,
  tfrd_cfg_if.sink   cfg_ch
);

  localparam int PW = $clog2(FRAME_BYTES);

  tfrd_pkg::tfrd_cfg_t    cfg_r, cfg_nxt;
  tfrd_pkg::tfrd_result_t res;
  tfrd_pkg::tfrd_status_t status;
  logic                   res_valid, res_ready;
  logic                   wr_en, rd_en;
  logic [PW-1:0]          wr_addr, rd_addr;
  tfrd_pkg::byte_t        wr_data, rd_data;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        tfrd_pkg::CFG_IDX_TYPE_CODE: cfg_nxt.frame_type_code = cfg_ch.data;
        tfrd_pkg::CFG_IDX_TOP_ID:    cfg_nxt.top_source_id   = cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{frame_type_code: tfrd_pkg::TYPE_CODE_RST,
                 top_source_id:   tfrd_pkg::TOP_ID_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tfrd_seq #(
    .FRAME_BYTES  (FRAME_BYTES),
    .MARKER_BYTES (MARKER_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.rx_byte),
    .in_ready  (in_ch.ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .status    (status)
  );

  tfrd_window_mem #(
    .DEPTH (FRAME_BYTES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tfrd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

  `TFRD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while previous byte still in work")
  `TFRD_ASSERT_NOW(a_idle_no_pending, clk, rst_n, status.idle, !status.pend_mark, "marker event left pending at idle")
  `TFRD_ASSERT_NEXT(a_last_ends_run, clk, rst_n, res_valid && res_ready && res.last_of_run, status.idle, "sequencer busy after last result of run")
  `TFRD_ASSERT_NOW(a_marker_zero_byte, clk, rst_n, out_ch.valid && out_ch.out_kind, out_ch.out_byte == 8'h00, "marker event carries nonzero byte")

endmodule
